FILE: src/ufr_pkg.sv
// Shared types and codes for the frame receiver: parser states, event codes,
// and the item structs passed between stages. No dependencies.
package ufr_pkg;

   localparam logic [7:0] SYNC_A5   = 8'hA5;
   localparam logic [7:0] SYNC_5A   = 8'h5A;
   localparam logic [7:0] ACK_OK_ST = 8'h00;
   localparam logic [15:0] MIN_LENGTH = 16'd4;
   localparam logic [15:0] CRC_BYTES  = 16'd2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [3:0] {
      ST_HUNT  = 4'd0,
      ST_SYNC2 = 4'd1,
      ST_LENH  = 4'd2,
      ST_LENL  = 4'd3,
      ST_CMD   = 4'd4,
      ST_SEQ   = 4'd5,
      ST_BODY  = 4'd6,
      ST_HOLD  = 4'd7,
      ST_ACK2  = 4'd8,
      ST_ACKST = 4'd9
   } parse_state_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_BYTE   = 3'd1,
      EV_DONE   = 3'd2,
      EV_ACKOK  = 3'd3,
      EV_ACKBAD = 3'd4,
      EV_LENERR = 3'd5
   } event_type;

   typedef enum logic {
      CMD_BYTE    = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic [7:0]  rx_byte;
      logic        ack_expected;
   } req_item_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic [7:0]  frame_cmd;
      logic [7:0]  frame_seq;
      logic [15:0] frame_crc;
   } rsp_item_type;

endpackage

FILE: src/uart_frame_receiver.sv
// Top level of the frame receiver: input register, parser, result register.
// Depends on ufr_pkg, ufr_in_reg, ufr_parser and ufr_out_reg.
//
// Usage:
//   The req_ channel carries one received serial byte per word, or a release
//   word (req_tuser = 1) that sends the parser back to hunting for A5 5A.
//   The rsp_ channel returns exactly one result word for every request word,
//   in order: an event code in rsp_tuser plus body byte and index; at frame
//   end also the header fields and CRC, and on a short length the header fields.
//   rsp_tvalid rises once the accepted word moves from the input register
//   into the result register, which waits while a held result is not taken;
//   a new word is accepted every cycle as long as results are taken. The parser
//   state advances once per word, between the input register and the result
//   register.
//   When the result side stalls, one result waits in the result register and
//   one more request word is held in the input register; req_tready then
//   drops until the result is taken.
//   Reset clears both valid flags and all parser state (hunting, zero length,
//   command, sequence, count and previous byte). No clearing pass is needed.
module uart_frame_receiver (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] rx_byte, [8] ack_expected, [15:9] zero
   input  logic [ufr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] data_byte, [23:8] byte_index, [39:24] frame_length,
   // [47:40] frame_cmd, [55:48] frame_seq, [71:56] frame_crc
   output logic [ufr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] event_res
   output logic [2:0]                     rsp_tuser
);
   import ufr_pkg::*;

   req_item_type req_item, s1_item;
   rsp_item_type step_result, rsp_item;
   logic         s1_valid;
   logic         advance;
   logic         fire;

   // unpack the request word
   always_comb begin
      req_item.command      = command_type'(req_tuser);
      req_item.rx_byte      = req_tdata[7:0];
      req_item.ack_expected = req_tdata[8];
   end

   ufr_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .advance   (advance),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   // step the parser only when the word moves into the result register
   assign fire = s1_valid && advance;

   ufr_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s1_item),
      .result (step_result)
   );

   ufr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_item   (step_result),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // pack the result word, first field lowest
   assign rsp_tdata = {rsp_item.frame_crc, rsp_item.frame_seq, rsp_item.frame_cmd,
                       rsp_item.frame_length, rsp_item.byte_index, rsp_item.data_byte};
   assign rsp_tuser = rsp_item.event_res;

   // a completed frame always had a legal length and ends on its last index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.event_res == EV_DONE) |->
         (rsp_item.frame_length >= MIN_LENGTH &&
          rsp_item.byte_index == rsp_item.frame_length - 16'd3))
      else $error("frame complete with bad length or index");

   // a length error is only reported for a short length field
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.event_res == EV_LENERR) |->
         (rsp_item.frame_length < MIN_LENGTH && rsp_item.frame_crc == '0))
      else $error("length error with legal length");

   // a body byte carries no header report
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.event_res == EV_BYTE) |->
         (rsp_item.frame_length == '0 && rsp_item.frame_crc == '0))
      else $error("body byte carries header fields");

   // no request word is taken while both stages are full and stalled
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request accepted with no room");

endmodule

FILE: src/ufr_in_reg.sv
// Input register of the frame receiver: captures one request word.
// Depends on ufr_pkg.
module ufr_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ufr_pkg::req_item_type in_item,
   input  logic                  advance,
   output logic                  out_valid,
   output ufr_pkg::req_item_type out_item
);
   import ufr_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // take a word when empty or when the held word moves on this cycle
   assign in_ready  = !valid_ff || advance;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

FILE: src/ufr_parser.sv
// Frame parser: state registers and the per-byte step that yields one result.
// Depends on ufr_pkg.
module ufr_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ufr_pkg::req_item_type item,
   output ufr_pkg::rsp_item_type result
);
   import ufr_pkg::*;

   parse_state_type state_ff, state_in;
   logic [15:0]     length_ff, length_in;
   logic [7:0]      cmd_ff, cmd_in;
   logic [7:0]      seq_ff, seq_in;
   logic [15:0]     count_ff, count_in;
   logic [7:0]      prev_ff, prev_in;
   logic [15:0]     count_inc;
   logic [7:0]      b;

   assign b         = item.rx_byte;
   assign count_inc = count_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         length_ff <= '0;
         cmd_ff    <= '0;
         seq_ff    <= '0;
         count_ff  <= '0;
         prev_ff   <= '0;
      end else if (fire) begin
         state_ff  <= state_in;
         length_ff <= length_in;
         cmd_ff    <= cmd_in;
         seq_ff    <= seq_in;
         count_ff  <= count_in;
         prev_ff   <= prev_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      length_in = length_ff;
      cmd_in    = cmd_ff;
      seq_in    = seq_ff;
      count_in  = count_ff;
      prev_in   = prev_ff;
      result    = '0;
      result.event_res = EV_NONE;

      if (item.command == CMD_RELEASE) begin
         state_in = ST_HUNT;
      end else begin
         unique case (state_ff)
            ST_SYNC2: begin
               state_in = (b == SYNC_5A) ? ST_LENH : ST_HUNT;
            end
            ST_LENH: begin
               length_in = {b, 8'h00};
               state_in  = ST_LENL;
            end
            ST_LENL: begin
               length_in = {length_ff[15:8], b};
               state_in  = ST_CMD;
            end
            ST_CMD: begin
               cmd_in   = b;
               state_in = ST_SEQ;
            end
            ST_SEQ: begin
               seq_in   = b;
               count_in = '0;
               if (length_ff < MIN_LENGTH) begin
                  result.event_res    = EV_LENERR;
                  result.frame_length = length_ff;
                  result.frame_cmd    = cmd_ff;
                  result.frame_seq    = b;
                  state_in            = ST_HUNT;
               end else begin
                  state_in = ST_BODY;
               end
            end
            ST_BODY: begin
               result.data_byte  = b;
               result.byte_index = count_ff;
               count_in          = count_inc;
               prev_in           = b;
               // length is at least four here, so the body count cannot wrap
               if (count_inc >= length_ff - CRC_BYTES) begin
                  result.event_res    = EV_DONE;
                  result.frame_length = length_ff;
                  result.frame_cmd    = cmd_ff;
                  result.frame_seq    = seq_ff;
                  result.frame_crc    = {prev_ff, b};
                  state_in            = ST_HOLD;
               end else begin
                  result.event_res = EV_BYTE;
               end
            end
            ST_HOLD: begin
               state_in = ST_HOLD;
            end
            ST_ACK2: begin
               state_in = (b == SYNC_A5) ? ST_ACKST : ST_HUNT;
            end
            ST_ACKST: begin
               result.event_res = (b == ACK_OK_ST) ? EV_ACKOK : EV_ACKBAD;
            end
            default: begin
               // hunting, and any code that means nothing
               if (b == SYNC_A5) begin
                  state_in = ST_SYNC2;
               end else if (item.ack_expected && (b == SYNC_5A)) begin
                  state_in = ST_ACK2;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         endcase
      end
   end

endmodule

FILE: src/ufr_out_reg.sv
// Result register of the frame receiver: holds a result until taken.
// Depends on ufr_pkg.
module ufr_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ufr_pkg::rsp_item_type in_item,
   output logic                  advance,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ufr_pkg::rsp_item_type out_item
);
   import ufr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // load when empty or when the held result is taken this cycle
   assign advance   = !valid_ff || out_ready;
   assign valid_in  = advance ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule
